>>> design/bbmls_pkg.sv
// ============================================================================
// bbmls_pkg
// Shared types, codes and helpers for the byte-addressed load/store memory.
// ============================================================================
package bbmls_pkg;

    // Default memory size in bytes.
    localparam int unsigned MEM_BYTES_DEF = 1024;

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // Access size codes.
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_DWORD = 2'd3;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ACCESS = 4'b0010,
        S_WAIT   = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    // Index of the last byte lane of an access of the given size.
    function automatic logic [2:0] last_lane(input logic [1:0] size_code);
        logic [2:0] lane;
        unique case (size_code)
            SIZE_BYTE:  lane = 3'd0;
            SIZE_HALF:  lane = 3'd1;
            SIZE_WORD:  lane = 3'd3;
            SIZE_DWORD: lane = 3'd7;
            default:    lane = 3'd0;
        endcase
        return lane;
    endfunction

endpackage

>>> design/bbmls_if.sv
// ============================================================================
// bbmls_req_if / bbmls_rsp_if
// Valid/ready channels for access requests and their responses.
// ============================================================================

// Access request channel.
interface bbmls_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [1:0]  size_code;
    logic        is_unsigned;
    logic [31:0] addr;
    logic [63:0] store_data;

    modport source (
        output valid, op, size_code, is_unsigned, addr, store_data,
        input  ready
    );
    modport sink (
        input  valid, op, size_code, is_unsigned, addr, store_data,
        output ready
    );
endinterface

// Access response channel.
interface bbmls_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] load_data;
    logic        fault;

    modport source (
        output valid, load_data, fault,
        input  ready
    );
    modport sink (
        input  valid, load_data, fault,
        output ready
    );
endinterface

>>> design/bbmls_byte_mem.sv
// ============================================================================
// bbmls_byte_mem
// Single-port byte-wide memory with a registered read.
// ============================================================================
module bbmls_byte_mem #(
    parameter int unsigned MEM_BYTES = bbmls_pkg::MEM_BYTES_DEF,
    localparam int unsigned AW = $clog2(MEM_BYTES)
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [MEM_BYTES];
    logic [7:0] rdata_reg;

    // Write and registered read share the one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/bounded_byte_memory_load_store.sv
// ============================================================================
// bounded_byte_memory_load_store
// Byte-addressed little-endian data memory with bounded load/store accesses.
// ============================================================================
//
//  Channel  Dir  Transfer carries
//  -------  ---  ------------------------------------------------------
//  req      in   op, size_code, is_unsigned, addr, store_data
//  rsp      out  load_data, fault
//
//  An access moves one byte per cycle through the single memory port.
//  A fault goes from the bound check straight to the done state; a load
//  also passes through S_WAIT for the registered read of its last byte.
//  A new request is taken as soon as the sequencer is idle, even while the
//  previous response still waits in the output register.
//  Reset clears the sequencer and output valid; memory contents are unknown.
//
module bounded_byte_memory_load_store #(
    parameter int unsigned MEM_BYTES = bbmls_pkg::MEM_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    bbmls_req_if.sink         req,
    bbmls_rsp_if.source       rsp
);

    localparam int unsigned AW = $clog2(MEM_BYTES);

    bbmls_pkg::state_t state_reg, state_next;

    logic          op_reg, op_next;
    logic          uns_reg, uns_next;
    logic [2:0]    last_reg, last_next;
    logic [2:0]    iss_reg, iss_next;
    logic [2:0]    rcv_reg, rcv_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [63:0]   data_reg, data_next;
    logic [63:0]   acc_reg, acc_next;
    logic          rvalid_reg, rvalid_next;
    logic [63:0]   res_data_reg, res_data_next;
    logic          res_fault_reg, res_fault_next;
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_data_reg, out_data_next;
    logic          out_fault_reg, out_fault_next;

    logic          accept;
    logic [32:0]   last_addr;
    logic          bound_fault;
    logic          mem_we;
    logic          mem_re;
    logic [7:0]    mem_rdata;
    logic          sign_bit;
    logic [63:0]   ext_data;

    // Byte storage.
    bbmls_byte_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (addr_reg),
        .wdata (data_reg[7:0]),
        .rdata (mem_rdata)
    );

    assign req.ready = (state_reg == bbmls_pkg::S_IDLE);
    assign accept    = req.valid && req.ready;

    // Bound check on the unwrapped address of the last byte.
    assign last_addr   = {1'b0, req.addr} + {30'd0, bbmls_pkg::last_lane(req.size_code)};
    assign bound_fault = (last_addr >= 33'(MEM_BYTES));

    // Final load value: earlier lanes, the arriving top byte, then extension.
    assign sign_bit = !uns_reg && mem_rdata[7];
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (3'(i) < rcv_reg)
            begin
                ext_data[8*i +: 8] = acc_reg[8*i +: 8];
            end
            else if (3'(i) == rcv_reg)
            begin
                ext_data[8*i +: 8] = mem_rdata;
            end
            else
            begin
                ext_data[8*i +: 8] = {8{sign_bit}};
            end
        end
    end

    // Sequencer and byte datapath.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        uns_next       = uns_reg;
        last_next      = last_reg;
        iss_next       = iss_reg;
        rcv_next       = rcv_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        acc_next       = acc_reg;
        res_data_next  = res_data_reg;
        res_fault_next = res_fault_reg;
        out_data_next  = out_data_reg;
        out_fault_next = out_fault_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bbmls_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = req.op;
                    uns_next  = req.is_unsigned;
                    last_next = bbmls_pkg::last_lane(req.size_code);
                    addr_next = req.addr[AW-1:0];
                    data_next = req.store_data;
                    acc_next  = 64'd0;
                    iss_next  = 3'd0;
                    rcv_next  = 3'd0;
                    if (bound_fault)
                    begin
                        res_data_next  = 64'd0;
                        res_fault_next = 1'b1;
                        state_next     = bbmls_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = bbmls_pkg::S_ACCESS;
                    end
                end
            end
            bbmls_pkg::S_ACCESS:
            begin
                if (op_reg == bbmls_pkg::OP_STORE)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_re = 1'b1;
                end
                addr_next = addr_reg + AW'(1);
                data_next = {8'd0, data_reg[63:8]};
                iss_next  = iss_reg + 3'd1;
                if (iss_reg == last_reg)
                begin
                    if (op_reg == bbmls_pkg::OP_STORE)
                    begin
                        res_data_next  = 64'd0;
                        res_fault_next = 1'b0;
                        state_next     = bbmls_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = bbmls_pkg::S_WAIT;
                    end
                end
            end
            bbmls_pkg::S_WAIT:
            begin
                // The last read byte is collected below.
            end
            bbmls_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_data_reg;
                    out_fault_next = res_fault_reg;
                    state_next     = bbmls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bbmls_pkg::S_IDLE;
            end
        endcase

        // Collect read bytes in the cycle after they were issued.
        if (rvalid_reg)
        begin
            if (rcv_reg == last_reg)
            begin
                res_data_next  = ext_data;
                res_fault_next = 1'b0;
                state_next     = bbmls_pkg::S_DONE;
            end
            else
            begin
                acc_next[8*rcv_reg +: 8] = mem_rdata;
                rcv_next = rcv_reg + 3'd1;
            end
        end
    end

    assign rvalid_next = mem_re;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bbmls_pkg::S_IDLE;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        uns_reg       <= uns_next;
        last_reg      <= last_next;
        iss_reg       <= iss_next;
        rcv_reg       <= rcv_next;
        addr_reg      <= addr_next;
        data_reg      <= data_next;
        acc_reg       <= acc_next;
        res_data_reg  <= res_data_next;
        res_fault_reg <= res_fault_next;
        out_data_reg  <= out_data_next;
        out_fault_reg <= out_fault_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.load_data = out_data_reg;
    assign rsp.fault     = out_fault_reg;

endmodule

>>> design/bbmls_checker.sv
// ============================================================================
// bbmls_checker
// Port-level checks on the load/store memory, bound to the top level.
// ============================================================================
module bbmls_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] rsp_load_data,
    input logic        rsp_fault
);

    // A response held back keeps its valid.
    a_rsp_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response valid dropped while stalled");

    // A stalled response keeps its payload.
    a_rsp_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_load_data) && $stable(rsp_fault))
        else $error("response payload changed while stalled");

    // A faulting access returns no data.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_fault |-> rsp_load_data == 64'd0)
        else $error("fault response carries data");

    // One access at a time: the request side closes after a transfer.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an access is in progress");

    // No response can appear in the cycle right after a request transfer.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_valid && req_ready))
        else $error("response appeared too early");

endmodule

bind bounded_byte_memory_load_store bbmls_checker u_bbmls_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_load_data (rsp.load_data),
    .rsp_fault     (rsp.fault)
);

>>> dv/bounded_byte_memory_load_store_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// bounded_byte_memory_load_store_tb
// Self-checking bench for the byte-addressed load/store memory. A shadow byte
// image predicts every response. Stimulus is a directed sweep of sizes,
// extensions, unaligned and out-of-bounds accesses, then random traffic under
// varying sender and receiver idling, with one long receiver hold-off.
// ============================================================================
module bounded_byte_memory_load_store_tb;

    localparam int unsigned MEM_BYTES        = bbmls_pkg::MEM_BYTES_DEF;
    localparam int unsigned AW               = $clog2(MEM_BYTES);
    localparam int unsigned RANDOM_PER_PHASE = 170;
    localparam int unsigned HOLD_CYCLES      = 300;
    localparam int unsigned DRAIN_CYCLES     = 30;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam int unsigned RECENT_DEPTH     = 16;

    typedef struct {
        logic [63:0] load_data;
        logic        fault;
    } response_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bbmls_req_if req_ch ();
    bbmls_rsp_if rsp_ch ();

    bounded_byte_memory_load_store #(
        .MEM_BYTES (MEM_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // True when the last byte of the access lies at or past the end of memory.
    function automatic bit beyond_end(input logic [31:0] addr, input logic [1:0] size_code);
        longint unsigned last_byte;
        last_byte = longint'(addr) + (longint'(1) << size_code) - 1;
        return last_byte >= MEM_BYTES;
    endfunction

    // Shadow memory image that predicts and checks every response in order.
    class memory_image_checker;
        bit [7:0]    image [MEM_BYTES];
        response_t   pending [$];
        int unsigned mismatches;
        int unsigned loads;
        int unsigned stores;
        int unsigned faults;

        function void flag_mismatch(input string what, input logic [63:0] exp,
                                    input logic [63:0] act);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: mismatch on %s: expected %h, got %h", $time, what, exp, act);
        endfunction

        // Predict the response of one accepted access and update the image.
        function void note_request(input logic op, input logic [1:0] size_code,
                                   input logic is_unsigned, input logic [31:0] addr,
                                   input logic [63:0] store_data);
            response_t   exp;
            logic [63:0] raw;
            int unsigned count;
            int unsigned width;
            count         = 1 << size_code;
            width         = 8 * count;
            exp.load_data = '0;
            exp.fault     = 1'b0;
            if (beyond_end(addr, size_code))
            begin
                exp.fault = 1'b1;
                faults++;
            end
            else if (op == bbmls_pkg::OP_STORE)
            begin
                for (int unsigned i = 0; i < count; i++)
                    image[AW'(addr + i)] = store_data[8 * i +: 8];
                stores++;
            end
            else
            begin
                raw = '0;
                for (int unsigned i = 0; i < count; i++)
                    raw[8 * i +: 8] = image[AW'(addr + i)];
                if (!is_unsigned && count < 8 && raw[width - 1])
                    raw = raw | (~64'd0 << width);
                exp.load_data = raw;
                loads++;
            end
            pending.push_back(exp);
        endfunction

        // Compare one response transfer with the oldest prediction.
        function void check_response(input logic [63:0] load_data, input logic fault);
            response_t exp;
            if (pending.size() == 0)
            begin
                flag_mismatch("response with no access pending", '0, load_data);
                return;
            end
            exp = pending.pop_front();
            if (load_data !== exp.load_data)
                flag_mismatch("load_data", exp.load_data, load_data);
            if (fault !== exp.fault)
                flag_mismatch("fault", 64'(exp.fault), 64'(fault));
        endfunction
    endclass

    memory_image_checker tracker;

    // Stimulus bookkeeping: which bytes hold data, and where stores went lately.
    bit          written [MEM_BYTES];
    logic [31:0] recent_stores [$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_req;
    bit          hold_taken;
    int unsigned stall_left;
    int unsigned input_stall_cycles;
    int unsigned cycle_count;

    // Clock generation.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: random ready, plus one long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
            hold_taken   <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= HOLD_CYCLES;
            hold_taken   <= 1'b1;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor both channels at each rising edge.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            tracker.note_request(req_ch.op, req_ch.size_code, req_ch.is_unsigned,
                                 req_ch.addr, req_ch.store_data);
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_response(rsp_ch.load_data, rsp_ch.fault);
        if (rst_n && stall_left != 0 && req_ch.valid && !req_ch.ready)
            input_stall_cycles++;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bit range_written(input logic [31:0] addr, input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            if (!written[AW'(addr + i)])
                return 1'b0;
        return 1'b1;
    endfunction

    // Offer one access, with random idle cycles first, and wait for its transfer.
    task automatic issue_access(input logic op, input logic [1:0] size_code,
                                input logic is_unsigned, input logic [31:0] addr,
                                input logic [63:0] store_data);
        int unsigned count;
        count = 1 << size_code;
        if (op == bbmls_pkg::OP_STORE && !beyond_end(addr, size_code))
        begin
            for (int unsigned i = 0; i < count; i++)
                written[AW'(addr + i)] = 1'b1;
            recent_stores.push_back(addr);
            if (recent_stores.size() > RECENT_DEPTH)
                void'(recent_stores.pop_front());
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.size_code   <= size_code;
        req_ch.is_unsigned <= is_unsigned;
        req_ch.addr        <= addr;
        req_ch.store_data  <= store_data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // One random access: mostly in-range loads and stores, some out of bounds.
    task automatic random_access();
        logic        op;
        logic        is_unsigned;
        logic [1:0]  size_code;
        logic [31:0] addr;
        logic [63:0] data;
        int unsigned count;
        int unsigned pick;
        size_code   = 2'($urandom_range(3));
        count       = 1 << size_code;
        is_unsigned = 1'($urandom_range(1));
        data        = {$urandom, $urandom};
        op          = 1'($urandom_range(1));
        pick        = $urandom_range(99);
        if (pick < 4)
            addr = $urandom;
        else if (pick < 8)
            addr = 32'hFFFF_FFFF - $urandom_range(15);
        else if (pick < 12)
            addr = MEM_BYTES - count + 1 + $urandom_range(6);
        else if (pick < 45 && recent_stores.size() != 0)
        begin
            // Read back near a recent store so loads find written bytes.
            op   = bbmls_pkg::OP_LOAD;
            addr = recent_stores[$urandom_range(recent_stores.size() - 1)]
                   + $urandom_range(7);
            if (addr > MEM_BYTES - count)
                addr = MEM_BYTES - count;
        end
        else
        begin
            addr = $urandom_range(MEM_BYTES - count);
            op   = ($urandom_range(99) < 50) ? bbmls_pkg::OP_LOAD : bbmls_pkg::OP_STORE;
        end
        // A load must never touch a byte that was not written yet.
        if (op == bbmls_pkg::OP_LOAD && !beyond_end(addr, size_code)
            && !range_written(addr, count))
            op = bbmls_pkg::OP_STORE;
        issue_access(op, size_code, is_unsigned, addr, data);
    endtask

    // Main sequence.
    initial
    begin
        tracker            = new();
        send_idle_pct      = 34;
        recv_idle_pct      = 66;
        hold_req           = 1'b0;
        input_stall_cycles = 0;
        cycle_count        = 0;
        req_ch.valid       = 1'b0;
        req_ch.op          = bbmls_pkg::OP_LOAD;
        req_ch.size_code   = bbmls_pkg::SIZE_BYTE;
        req_ch.is_unsigned = 1'b0;
        req_ch.addr        = '0;
        req_ch.store_data  = '0;
        rsp_ch.ready       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every size, both extensions, unaligned, memory edges.
        issue_access(bbmls_pkg::OP_STORE, bbmls_pkg::SIZE_DWORD, 1'b0, 32'd0,
                     64'h8877_6655_4433_2211);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_DWORD, 1'b0, 32'd0,
                     64'hFFFF_FFFF_FFFF_FFFF);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_BYTE,  1'b0, 32'd0, '0);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_BYTE,  1'b0, 32'd7, '0);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_BYTE,  1'b1, 32'd7, '0);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_HALF,  1'b0, 32'd6, '0);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_HALF,  1'b1, 32'd6, '0);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_WORD,  1'b0, 32'd1, '0);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_WORD,  1'b0, 32'd4, '0);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_WORD,  1'b1, 32'd4, '0);
        issue_access(bbmls_pkg::OP_STORE, bbmls_pkg::SIZE_HALF,  1'b1, 32'd3,
                     64'hFFFF_FFFF_FFFF_A5C3);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_DWORD, 1'b1, 32'd0, '0);
        issue_access(bbmls_pkg::OP_STORE, bbmls_pkg::SIZE_DWORD, 1'b1, MEM_BYTES - 8,
                     64'hFFFF_FFFF_FFFF_FFFF);
        issue_access(bbmls_pkg::OP_STORE, bbmls_pkg::SIZE_BYTE,  1'b0, MEM_BYTES - 1,
                     64'h0123_4567_89AB_CD80);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_DWORD, 1'b0, MEM_BYTES - 8, '0);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_BYTE,  1'b0, MEM_BYTES - 1, '0);
        // Mostly out of bounds, including addresses that would wrap past 2^32.
        issue_access(bbmls_pkg::OP_STORE, bbmls_pkg::SIZE_HALF,  1'b0, MEM_BYTES - 1,
                     64'h0000_0000_0000_1234);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_BYTE,  1'b1, MEM_BYTES - 1, '0);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_DWORD, 1'b0, MEM_BYTES - 7, '0);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_BYTE,  1'b0, MEM_BYTES, '0);
        issue_access(bbmls_pkg::OP_STORE, bbmls_pkg::SIZE_WORD,  1'b1, 32'hFFFF_FFFF,
                     64'hDEAD_BEEF_CAFE_F00D);
        issue_access(bbmls_pkg::OP_STORE, bbmls_pkg::SIZE_DWORD, 1'b0, 32'hFFFF_FFF9,
                     64'h5555_AAAA_5555_AAAA);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_WORD,  1'b1, 32'hFFFF_FFFE, '0);
        issue_access(bbmls_pkg::OP_LOAD,  bbmls_pkg::SIZE_DWORD, 1'b0, 32'd0, '0);

        // Random, phase one: sender idles lightly, receiver heavily.
        repeat (RANDOM_PER_PHASE) random_access();

        // Random, phase two: the other way round.
        send_idle_pct = 66;
        recv_idle_pct <= 34;
        repeat (RANDOM_PER_PHASE) random_access();

        // Random, phase three: no idling, opened by a long receiver hold-off.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_req      <= 1'b1;
        repeat (RANDOM_PER_PHASE) random_access();
        req_ch.valid <= 1'b0;

        // Drain outstanding responses, then let the block settle.
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d accesses: %0d loads, %0d stores, %0d out of bounds.",
                 tracker.loads + tracker.stores + tracker.faults,
                 tracker.loads, tracker.stores, tracker.faults);
        $display("Input held off for %0d cycles under backpressure; %0d mismatches.",
                 input_stall_cycles, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
